FILE: sv/plpl_pkg.sv
// ----------------------------------------------------------------------------
// plpl_pkg
// Shared types and codes for the piecewise-linear profile lookup unit.
// ----------------------------------------------------------------------------
package plpl_pkg;

   localparam int KEY_W = 16;
   localparam int VAL_W = 32;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic                    req_type;
      logic [2:0]              table_select;
      logic [3:0]              entry_index;
      logic [KEY_W-1:0]        point_key;
      logic signed [VAL_W-1:0] point_value;
      logic [KEY_W-1:0]        query_key;
   } plpl_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] result_value;
      logic                    found;
   } plpl_rsp_type;

endpackage

FILE: sv/piecewise_linear_profile_lookup_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_profile_lookup_unit
// Breakpoint tables of (key, value) points, linear interpolation on query.
// A write stores one point and makes its index the last point of the table.
// A query with key 0, an empty table or a table out of range goes straight
// to the hand-off to the output register. Otherwise the unit scans the
// table through a registered read of the point memory, reading and then
// comparing each point in turn, then does the 32x16 multiply, runs a
// bit-serial divider and hands the result to the output register. A scan
// that finds no point stops after the last point of the table. One item is
// worked on at a time; a finished result waits in the output register while
// the next item is taken in. Points must be written with ascending keys.
// ----------------------------------------------------------------------------
module piecewise_linear_profile_lookup_unit #(
   parameter int ENTRIES = 16,
   parameter int TABLES  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  plpl_pkg::plpl_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output plpl_pkg::plpl_rsp_type rsp_data
);

   localparam int DEPTH = TABLES * ENTRIES;
   localparam int AW    = $clog2(DEPTH);
   localparam int IW    = $clog2(ENTRIES);
   localparam int CW    = $clog2(ENTRIES + 1);
   localparam int TW    = (TABLES > 1) ? $clog2(TABLES) : 1;
   localparam int KW    = plpl_pkg::KEY_W;
   localparam int VW    = plpl_pkg::VAL_W;

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;   // point read in flight
   localparam logic [2:0] S_CMP  = 3'd2;   // compare point against key
   localparam logic [2:0] S_MUL  = 3'd3;   // |dv| * dq
   localparam logic [2:0] S_DIV  = 3'd4;   // restoring divide, 1 bit/cycle
   localparam logic [2:0] S_FIN  = 3'd5;   // hand result to output reg

   // point memory: {key, value}
   logic [KW+VW-1:0] mem [DEPTH];
   logic [KW+VW-1:0] rd_ff;

   logic [2:0]           state_ff, state_in;
   logic [2:0]           tbl_ff, tbl_in;
   logic [KW-1:0]        qkey_ff, qkey_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [KW-1:0]        prev_key_ff, prev_key_in;
   logic signed [VW-1:0] prev_val_ff, prev_val_in;
   logic [KW-1:0]        span_ff, span_in;
   logic [KW-1:0]        dq_ff, dq_in;
   logic [VW-1:0]        mag_ff, mag_in;
   logic                 neg_ff, neg_in;
   logic [KW-1:0]        rem_ff, rem_in;
   logic [VW-1:0]        quo_ff, quo_in;
   logic [4:0]           step_ff, step_in;
   logic                 found_ff, found_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   plpl_pkg::plpl_rsp_type rsp_data_ff, rsp_data_in;
   logic [CW-1:0]        counts_ff [TABLES];
   logic [CW-1:0]        counts_in [TABLES];

   logic                 req_xfer;
   logic                 tbl_ok;
   logic                 entry_ok;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;
   logic [CW-1:0]        cnt_sel;
   logic [8:0]           entry_next;
   logic [KW-1:0]        rd_key;
   logic signed [VW-1:0] rd_val;
   logic [VW:0]          dv;
   logic [VW:0]          dv_neg;
   logic [KW+VW-1:0]     prod;
   logic [KW:0]          trial;
   logic [KW:0]          trial_sub;
   logic                 trial_ge;
   logic [VW:0]          quo_signed;
   logic [VW:0]          res_sum;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign tbl_ok     = ({2'b00, req_data.table_select} < 5'(TABLES));
   assign entry_ok   = ({5'b0, req_data.entry_index} < 9'(ENTRIES));
   assign wr_en      = req_xfer && (req_data.req_type == plpl_pkg::REQ_WRITE)
                       && tbl_ok && entry_ok;
   assign entry_next = {5'b0, req_data.entry_index} + 9'd1;
   assign wr_addr    = AW'(req_data.table_select) * AW'(ENTRIES)
                       + AW'(req_data.entry_index);
   assign rd_addr    = AW'(tbl_ff) * AW'(ENTRIES) + AW'(idx_ff);
   assign cnt_sel    = tbl_ok ? counts_ff[TW'(req_data.table_select)] : '0;

   assign rd_key = rd_ff[KW+VW-1:VW];
   assign rd_val = rd_ff[VW-1:0];

   // value delta, sign split off for the unsigned divider
   assign dv     = {rd_val[VW-1], rd_val} - {prev_val_ff[VW-1], prev_val_ff};
   assign dv_neg = -dv;

   assign prod = {{KW{1'b0}}, mag_ff} * {{VW{1'b0}}, dq_ff};

   assign trial     = {rem_ff, quo_ff[VW-1]};
   assign trial_sub = trial - {1'b0, span_ff};
   assign trial_ge  = (trial >= {1'b0, span_ff});

   assign quo_signed = neg_ff ? -{1'b0, quo_ff} : {1'b0, quo_ff};
   assign res_sum    = {prev_val_ff[VW-1], prev_val_ff} + quo_signed;

   always_comb begin
      state_in     = state_ff;
      tbl_in       = tbl_ff;
      qkey_in      = qkey_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      prev_key_in  = prev_key_ff;
      prev_val_in  = prev_val_ff;
      span_in      = span_ff;
      dq_in        = dq_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      found_in     = found_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      counts_in    = counts_ff;

      if (wr_en) begin
         counts_in[TW'(req_data.table_select)] = CW'(entry_next);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req_data.req_type == plpl_pkg::REQ_QUERY)) begin
               tbl_in      = req_data.table_select;
               qkey_in     = req_data.query_key;
               cnt_in      = cnt_sel;
               idx_in      = '0;
               prev_key_in = '0;
               prev_val_in = '0;
               quo_in      = '0;
               neg_in      = 1'b0;
               if (req_data.query_key == '0) begin
                  found_in = 1'b1;
                  state_in = S_FIN;
               end else if (cnt_sel == '0) begin
                  found_in = 1'b0;
                  state_in = S_FIN;
               end else begin
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (qkey_ff > rd_key) begin
               prev_key_in = rd_key;
               prev_val_in = rd_val;
               if (CW'(idx_ff) + CW'(1) == cnt_ff) begin
                  // ran off the end of the table
                  prev_val_in = '0;
                  quo_in      = '0;
                  neg_in      = 1'b0;
                  found_in    = 1'b0;
                  state_in    = S_FIN;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_RD;
               end
            end else begin
               span_in  = rd_key - prev_key_ff;
               dq_in    = qkey_ff - prev_key_ff;
               neg_in   = dv[VW];
               mag_in   = dv[VW] ? dv_neg[VW-1:0] : dv[VW-1:0];
               found_in = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // quotient <= |dv| < 2^32, so the high half is already below span
            rem_in   = prod[KW+VW-1:VW];
            quo_in   = prod[VW-1:0];
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_sub[KW-1:0] : trial[KW-1:0];
            quo_in  = {quo_ff[VW-2:0], trial_ge};
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = res_sum[VW-1:0];
               rsp_data_in.found        = found_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int t = 0; t < TABLES; t++) begin
            counts_ff[t] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         counts_ff    <= counts_in;
      end
      tbl_ff      <= tbl_in;
      qkey_ff     <= qkey_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      prev_key_ff <= prev_key_in;
      prev_val_ff <= prev_val_in;
      span_ff     <= span_in;
      dq_ff       <= dq_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      step_ff     <= step_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   // point memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {req_data.point_key, req_data.point_value};
      end
      rd_ff <= mem[rd_addr];
   end

   // divider operands stay sane
   a_span_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> ((span_ff != '0) && (dq_ff <= span_ff)))
      else $error("interpolation span zero or key past upper point");

   a_rem_below_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < span_ff))
      else $error("divider remainder not below divisor");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("response raised outside of result hand-off");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && (req_data.req_type == plpl_pkg::REQ_QUERY))
      |=> (state_ff != S_IDLE))
      else $error("query transfer did not start the sequencer");

endmodule
